// ----- src/cft_pkg.sv -----
// ----------------------------------------------------------------------------
// Cumulative frequency tree package
// Shared widths, operation codes and the request and result records passed
// between the top level and the tree core.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int SYM_W       = 8;
  localparam int NUM_SYMBOLS = 2 ** SYM_W;
  localparam int COUNT_W     = 24;
  localparam int INC_W       = 16;
  localparam int OP_W        = 2;
  localparam int ADDR_W      = SYM_W + 1;
  localparam int TREE_DEPTH  = 2 ** ADDR_W;
  localparam int LEVEL_W     = $clog2(SYM_W + 2);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [SYM_W-1:0]        symbol;
    logic signed [INC_W-1:0] increment;
    logic [COUNT_W-1:0]      target;
  } req_t;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [COUNT_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic ready;
    logic hold;
  } status_t;

  // Levels are stored leaves first; a level of n nodes begins at 2*N - 2*n.
  function automatic logic [ADDR_W-1:0] node_addr(input logic [LEVEL_W-1:0] level,
                                                   input logic [SYM_W-1:0] idx);
    logic [ADDR_W:0] base;
    base = (ADDR_W+1)'(TREE_DEPTH) - ((ADDR_W+1)'(TREE_DEPTH) >> level);
    return base[ADDR_W-1:0] + {1'b0, idx};
  endfunction

endpackage

// ----- src/cft_core.sv -----
// ----------------------------------------------------------------------------
// Cumulative frequency tree core
// Holds the sum tree in one synchronous memory and walks it one level per
// cycle for add, query and decode operations.
// ----------------------------------------------------------------------------
module cft_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cft_pkg::req_t   req,
  input  logic            take,
  output cft_pkg::status_t status,
  output cft_pkg::res_t   res
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  localparam int STEP_W = cft_pkg::LEVEL_W;
  localparam logic [STEP_W-1:0] LAST_READ = STEP_W'(cft_pkg::SYM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(cft_pkg::SYM_W + 1);

  logic [cft_pkg::COUNT_W-1:0] mem [cft_pkg::TREE_DEPTH];

  logic [1:0]                      state;
  logic [STEP_W-1:0]               step;
  logic [cft_pkg::OP_W-1:0]        cur_op;
  logic [cft_pkg::SYM_W-1:0]       cur_sym;
  logic [cft_pkg::COUNT_W-1:0]     cur_inc;
  logic [cft_pkg::COUNT_W-1:0]     remain;
  logic [cft_pkg::COUNT_W-1:0]     start_sum;
  logic [cft_pkg::COUNT_W-1:0]     count;
  logic [cft_pkg::SYM_W-1:0]       path;
  logic [cft_pkg::ADDR_W-1:0]      prev_addr;
  logic [cft_pkg::ADDR_W-1:0]      clr_addr;
  logic [cft_pkg::COUNT_W-1:0]     rdata;

  logic [cft_pkg::COUNT_W-1:0]     remain_next;
  logic [cft_pkg::COUNT_W-1:0]     start_sum_next;
  logic [cft_pkg::COUNT_W-1:0]     count_next;
  logic [cft_pkg::SYM_W-1:0]       path_next;

  logic                            rd_en;
  logic [cft_pkg::ADDR_W-1:0]      rd_addr;
  logic [cft_pkg::LEVEL_W-1:0]     rd_lvl;
  logic [cft_pkg::SYM_W-1:0]       rd_idx;
  logic                            wr_en;
  logic [cft_pkg::ADDR_W-1:0]      wr_addr;
  logic [cft_pkg::COUNT_W-1:0]     wr_data;
  logic                            proc;
  logic [STEP_W-1:0]               j;
  logic                            go_right;
  logic [cft_pkg::COUNT_W-1:0]     updated;

  assign proc    = (state == ST_RUN) && (step != '0);
  assign j       = step - STEP_W'(1);
  assign updated = rdata + cur_inc;

  always_comb begin
    remain_next    = remain;
    start_sum_next = start_sum;
    count_next     = count;
    path_next      = path;
    go_right       = 1'b0;
    if (proc) begin
      case (cur_op)
        cft_pkg::OP_ADD: begin
          if (j == '0) begin
            count_next = updated;
          end
        end
        cft_pkg::OP_QUERY: begin
          if (j == '0) begin
            count_next = rdata;
          end else if (((cur_sym >> (j - STEP_W'(1))) & cft_pkg::SYM_W'(1)) != '0) begin
            start_sum_next = start_sum + rdata;
          end
        end
        cft_pkg::OP_DECODE: begin
          if (j == LAST_READ) begin
            count_next = rdata;
          end else begin
            go_right  = (remain >= rdata);
            path_next = {path[cft_pkg::SYM_W-2:0], go_right};
            if (go_right) begin
              remain_next    = remain - rdata;
              start_sum_next = start_sum + rdata;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_lvl = '0;
    rd_idx = '0;
    case (cur_op)
      cft_pkg::OP_ADD: begin
        rd_lvl = step;
        rd_idx = cur_sym >> step;
      end
      cft_pkg::OP_QUERY: begin
        if (step == '0) begin
          rd_idx = cur_sym;
        end else begin
          rd_lvl = j;
          rd_idx = (cur_sym >> j) & ~cft_pkg::SYM_W'(1);
        end
      end
      cft_pkg::OP_DECODE: begin
        if (step == LAST_READ) begin
          rd_idx = path_next;
        end else begin
          rd_lvl = cft_pkg::LEVEL_W'(cft_pkg::SYM_W - 1) - step;
          rd_idx = {path_next[cft_pkg::SYM_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    rd_addr = cft_pkg::node_addr(rd_lvl, rd_idx);
    rd_en   = (state == ST_RUN) && (step <= LAST_READ);
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = proc && (cur_op == cft_pkg::OP_ADD);
      wr_addr = prev_addr;
      wr_data = updated;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      step     <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + cft_pkg::ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_op    <= req.op;
      cur_sym   <= req.symbol;
      cur_inc   <= cft_pkg::COUNT_W'(req.increment);
      remain    <= req.target;
      start_sum <= '0;
      count     <= '0;
      path      <= '0;
    end else begin
      remain    <= remain_next;
      start_sum <= start_sum_next;
      count     <= count_next;
      path      <= path_next;
    end
    prev_addr <= rd_addr;
  end

  assign status.ready = (state == ST_IDLE);
  assign status.hold  = (state == ST_HOLD);
  assign res.symbol   = (cur_op == cft_pkg::OP_DECODE) ? path : cur_sym;
  assign res.start    = start_sum;
  assign res.count    = count;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("operation started while the core was busy");

  a_read_before_use: assert property (@(posedge clk) disable iff (rst)
    proc |-> $past(rd_en))
    else $error("tree data used without a read in the previous cycle");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cur_op != cft_pkg::OP_ADD) |-> !wr_en)
    else $error("tree written by an operation other than add");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && !take) |=> (state == ST_HOLD && $stable(res)))
    else $error("held result changed before it was taken");

endmodule

// ----- src/cumulative_frequency_tree.sv -----
// ----------------------------------------------------------------------------
// Cumulative frequency tree
// Symbol frequency model for an arithmetic coder: add, query and decode on a
// binary sum tree of 256 symbol counts.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   op, symbol, increment, target
//   out      output     out_valid / out_stall found_symbol, range_start,
//                                             symbol_count
//
// Every operation walks the nine tree levels with one memory read per cycle,
// and a new item is accepted only once the previous one has left the core.
// After reset all 512 tree words are cleared; in_stall is high meanwhile.
// A finished result sits in the output register while the next item runs.
// If the output register is still full, the core holds its result and
// accepts no new item until the output transfer frees it.
// ----------------------------------------------------------------------------
module cumulative_frequency_tree (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cft_pkg::OP_W-1:0]          op,
  input  logic [cft_pkg::SYM_W-1:0]         symbol,
  input  logic signed [cft_pkg::INC_W-1:0]  increment,
  input  logic [cft_pkg::COUNT_W-1:0]       target,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cft_pkg::SYM_W-1:0]         found_symbol,
  output logic [cft_pkg::COUNT_W-1:0]       range_start,
  output logic [cft_pkg::COUNT_W-1:0]       symbol_count
);

  cft_pkg::req_t    req;
  cft_pkg::res_t    res;
  cft_pkg::status_t status;
  logic             start;
  logic             take;

  assign req.op        = op;
  assign req.symbol    = symbol;
  assign req.increment = increment;
  assign req.target    = target;

  assign in_stall = !status.ready;
  assign start    = in_valid && !in_stall;
  assign take     = status.hold && (!out_valid || !out_stall);

  cft_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .take   (take),
    .status (status),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found_symbol <= res.symbol;
      range_start  <= res.start;
      symbol_count <= res.count;
    end
  end

endmodule
